/* rtl/mwas_pkg.sv */
// ----------------------------------------------------------------------------
// mwas_pkg
// Shared types and constants of the maximum weight assignment solver.
// ----------------------------------------------------------------------------
package mwas_pkg;

    localparam int MAX_SIZE    = 16;
    localparam int WEIGHT_BITS = 16;
    localparam int IDX_W       = 5;   // index 0..MAX_SIZE
    localparam int ADDR_W      = 8;   // row*16+column
    localparam int POT_W       = 32;

    localparam logic signed [POT_W-1:0] SLACK_MAX = 32'sh3fff_ffff;

    // input transaction modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_SOLVE = 1'b1;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_PHASE,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_UPDATE,
        ST_AUG,
        ST_OUT_COL,
        ST_OUT_RD,
        ST_OUT_ACC,
        ST_EMIT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic init_clear;      // clear potentials, owners, links
        logic phase_start;     // begin row phase, reset slack and visited
        logic visit;           // mark current column visited, latch its owner
        logic scan_eval;       // issue next weight read, evaluate previous one
        logic scan_reset;      // restart scan
        logic update;          // apply step to one column
        logic aug_step;        // one augmenting path step
        logic out_start;       // start the output column search
        logic out_find;        // search column owned by output row
        logic out_issue;       // read weight for output row
        logic out_acc;         // accumulate weight
        logic emit_next;       // advance to the next result row
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic scan_done;       // scan column passed size
        logic no_next;         // no unvisited column found
        logic cur_owned;       // current column has an owner
        logic upd_done;        // update sweep done
        logic aug_done;        // path traced to column 0
        logic find_done;       // owner search done
        logic out_last;        // output row is the last one
        logic emit_last;       // result row is the last one
        logic phase_done;      // all rows processed
    } status_t;

endpackage

/* rtl/max_weight_assignment_solver_unit.sv */
// ----------------------------------------------------------------------------
// max_weight_assignment_solver_unit
// Maximum-weight perfect assignment of a square matrix (Hungarian method).
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: mode 0 writes one weight entry, accepted one per cycle while
//   idle, no result. mode 1 starts a solve; the block then holds s_ready low.
//   cfg_we/cfg_wdata set matrix_size while idle (0 acts as 1, above 16 as 16).
//   m_ channel: one transaction per row in ascending order; the last carries
//   the weight sum and last.
//   A solve runs one row phase per row. Each search step is a setup state, a
//   scan reading one weight a cycle from the memory's single read port, and
//   a sweep over the potentials of columns 0..n; row phase i takes up to i
//   steps and then an augment walk along the path. Gathering the result
//   finds each row's column and sums its weight, then the result rows follow.
//   The next item is accepted only after the final result transaction.
//   A stalled receiver simply holds the current result; nothing is lost.
//   Reset: synchronous, active low; matrix_size returns to 16, the weight
//   memory keeps its contents (undefined until loaded).
// ----------------------------------------------------------------------------
module max_weight_assignment_solver_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [4:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic [3:0]         s_row,
    input  logic [3:0]         s_column,
    input  logic signed [15:0] s_weight,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_assigned_row,
    output logic [3:0]         m_assigned_column,
    output logic signed [19:0] m_weight_sum,
    output logic               m_last
);

    mwas_pkg::cmd_t    cmd;
    mwas_pkg::status_t status;
    logic              load_en;

    // controller
    mwas_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_mode),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .load_en (load_en),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath
    mwas_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .load_en           (load_en),
        .s_row             (s_row),
        .s_column          (s_column),
        .s_weight          (s_weight),
        .cmd               (cmd),
        .status            (status),
        .m_assigned_row    (m_assigned_row),
        .m_assigned_column (m_assigned_column),
        .m_weight_sum      (m_weight_sum),
        .m_last            (m_last)
    );

endmodule

/* rtl/mwas_ctrl.sv */
// ----------------------------------------------------------------------------
// mwas_ctrl
// Controller state machine: sequences load, solve phases and result output.
// ----------------------------------------------------------------------------
module mwas_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_mode,
    output logic               s_ready,
    input  logic               m_ready,
    output logic               m_valid,
    output logic               load_en,
    input  mwas_pkg::status_t  status,
    output mwas_pkg::cmd_t     cmd
);

    mwas_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mwas_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mwas_pkg::ST_IDLE: begin
                if (s_valid && s_mode == mwas_pkg::MODE_SOLVE) state_next = mwas_pkg::ST_INIT;
            end
            mwas_pkg::ST_INIT:      state_next = mwas_pkg::ST_PHASE;
            mwas_pkg::ST_PHASE: begin
                if (status.phase_done) state_next = mwas_pkg::ST_OUT_COL;
                else                   state_next = mwas_pkg::ST_SCAN;
            end
            mwas_pkg::ST_SCAN: begin
                state_next = mwas_pkg::ST_SCAN_WAIT;
            end
            mwas_pkg::ST_SCAN_WAIT: begin
                if (status.scan_done) begin
                    if (status.no_next) state_next = mwas_pkg::ST_AUG;
                    else                state_next = mwas_pkg::ST_UPDATE;
                end else begin
                    state_next = mwas_pkg::ST_SCAN_WAIT;
                end
            end
            mwas_pkg::ST_UPDATE: begin
                if (status.upd_done) begin
                    if (status.cur_owned) state_next = mwas_pkg::ST_SCAN;
                    else                  state_next = mwas_pkg::ST_AUG;
                end
            end
            mwas_pkg::ST_AUG: begin
                if (status.aug_done) state_next = mwas_pkg::ST_PHASE;
            end
            mwas_pkg::ST_OUT_COL: begin
                if (status.find_done) state_next = mwas_pkg::ST_OUT_RD;
            end
            mwas_pkg::ST_OUT_RD:    state_next = mwas_pkg::ST_OUT_ACC;
            mwas_pkg::ST_OUT_ACC: begin
                if (status.out_last) state_next = mwas_pkg::ST_EMIT;
                else                 state_next = mwas_pkg::ST_OUT_COL;
            end
            mwas_pkg::ST_EMIT: begin
                if (m_ready && status.emit_last) state_next = mwas_pkg::ST_IDLE;
            end
            default: state_next = mwas_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        load_en = 1'b0;
        unique case (state_reg)
            mwas_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                load_en = s_valid && s_mode == mwas_pkg::MODE_LOAD;
            end
            mwas_pkg::ST_INIT:      cmd.init_clear  = 1'b1;
            mwas_pkg::ST_PHASE: begin
                cmd.phase_start = !status.phase_done;
                cmd.out_start   = status.phase_done;
            end
            mwas_pkg::ST_SCAN: begin
                cmd.visit      = 1'b1;
                cmd.scan_reset = 1'b1;
            end
            mwas_pkg::ST_SCAN_WAIT: cmd.scan_eval  = 1'b1;
            mwas_pkg::ST_UPDATE:    cmd.update     = 1'b1;
            mwas_pkg::ST_AUG:       cmd.aug_step   = 1'b1;
            mwas_pkg::ST_OUT_COL:   cmd.out_find   = 1'b1;
            mwas_pkg::ST_OUT_RD:    cmd.out_issue  = 1'b1;
            mwas_pkg::ST_OUT_ACC:   cmd.out_acc    = 1'b1;
            mwas_pkg::ST_EMIT: begin
                m_valid       = 1'b1;
                cmd.emit_next = m_ready;
            end
            default: ;
        endcase
    end

endmodule

/* rtl/mwas_dp.sv */
// ----------------------------------------------------------------------------
// mwas_dp
// Datapath: weight memory, potentials, slack scan, augmenting and output.
// ----------------------------------------------------------------------------
module mwas_dp (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [4:0]             cfg_wdata,
    input  logic                   load_en,
    input  logic [3:0]             s_row,
    input  logic [3:0]             s_column,
    input  logic signed [15:0]     s_weight,
    input  mwas_pkg::cmd_t         cmd,
    output mwas_pkg::status_t      status,
    output logic [3:0]             m_assigned_row,
    output logic [3:0]             m_assigned_column,
    output logic signed [19:0]     m_weight_sum,
    output logic                   m_last
);

    localparam int DIM = mwas_pkg::MAX_SIZE + 1;
    localparam int IW  = mwas_pkg::IDX_W;
    localparam int PW  = mwas_pkg::POT_W;
    localparam int WB  = mwas_pkg::WEIGHT_BITS;

    // weight memory
    logic signed [WB-1:0]     wmem [mwas_pkg::MAX_SIZE*mwas_pkg::MAX_SIZE];
    logic signed [WB-1:0]     rdata_reg;
    logic [mwas_pkg::ADDR_W-1:0] raddr;

    logic [4:0]               size_reg;
    logic [IW-1:0]            n;

    logic signed [PW-1:0]     u_reg    [DIM];
    logic signed [PW-1:0]     v_reg    [DIM];
    logic signed [PW-1:0]     minv_reg [DIM];
    logic [IW-1:0]            p_reg    [DIM];
    logic [IW-1:0]            way_reg  [DIM];
    logic [DIM-1:0]           used_reg;

    logic [IW-1:0]            row_i_reg;      // phase row
    logic [IW-1:0]            j0_reg;         // current column
    logic [IW-1:0]            i0_reg;         // its owner
    logic [IW-1:0]            j_reg;          // scan / sweep column
    logic                     pend_reg;       // read in flight
    logic [IW-1:0]            pend_j_reg;
    logic signed [PW-1:0]     delta_reg;
    logic [IW-1:0]            j1_reg;
    logic                     found_reg;

    logic [IW-1:0]            orow_reg;       // output row index 0-based
    logic [IW-1:0]            ocol_reg;       // found column 1-based
    logic signed [19:0]       total_reg;

    // result slot: column per row, filled during accumulation
    logic [3:0]               col_of_reg [mwas_pkg::MAX_SIZE];
    logic [IW-1:0]            emit_reg;

    logic signed [PW-1:0]     red, cur_min;
    logic [IW-1:0]            prev;

    // size in use
    always_comb begin
        if (size_reg == 5'd0)                         n = IW'(1);
        else if (size_reg > 5'(mwas_pkg::MAX_SIZE))   n = IW'(mwas_pkg::MAX_SIZE);
        else                                          n = size_reg;
    end

    // config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= 5'd16;
        end else if (cfg_we) begin
            size_reg <= cfg_wdata;
        end
    end

    // memory read address
    always_comb begin
        if (cmd.out_issue) begin
            raddr = {orow_reg[3:0], 4'(ocol_reg - IW'(1))};
        end else begin
            raddr = {4'(i0_reg - IW'(1)), 4'(j_reg - IW'(1))};
        end
    end

    // weight memory write and registered read
    always_ff @(posedge aclk) begin
        if (load_en) begin
            wmem[{s_row, s_column}] <= s_weight[WB-1:0];
        end
        rdata_reg <= wmem[raddr];
    end

    // reduced cost of the pending column
    assign red = -PW'(rdata_reg) - u_reg[i0_reg] - v_reg[pend_j_reg];
    assign cur_min = (red < minv_reg[pend_j_reg]) ? red : minv_reg[pend_j_reg];
    assign prev = way_reg[j0_reg];

    // status
    always_comb begin
        status.scan_done  = (j_reg > n) && !pend_reg;
        status.no_next    = !found_reg;
        status.cur_owned  = p_reg[j1_reg] != '0;
        status.upd_done   = (j_reg == n);
        status.aug_done   = (prev == '0);
        status.find_done  = (p_reg[j_reg] == IW'(orow_reg + IW'(1))) || (j_reg == n);
        status.out_last   = (orow_reg == IW'(n - IW'(1)));
        status.emit_last  = m_last;
        status.phase_done = (row_i_reg > n);
    end

    // solver state
    always_ff @(posedge aclk) begin
        if (cmd.init_clear) begin
            for (int k = 0; k < DIM; k++) begin
                u_reg[k]   <= '0;
                v_reg[k]   <= '0;
                p_reg[k]   <= '0;
                way_reg[k] <= '0;
            end
            row_i_reg <= IW'(1);
            orow_reg  <= '0;
            total_reg <= '0;
        end
        if (cmd.phase_start) begin
            p_reg[0] <= row_i_reg;
            j0_reg   <= '0;
            used_reg <= '0;
            for (int k = 0; k < DIM; k++) minv_reg[k] <= mwas_pkg::SLACK_MAX;
        end
        if (cmd.visit) begin
            used_reg[j0_reg] <= 1'b1;
            i0_reg           <= p_reg[j0_reg];
        end
        if (cmd.scan_reset) begin
            j_reg     <= IW'(1);
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
            delta_reg <= mwas_pkg::SLACK_MAX;
        end
        // scan: issue read at j_reg, evaluate previous one
        if (cmd.scan_eval) begin
            if (j_reg <= n) begin
                pend_reg   <= !used_reg[j_reg];
                pend_j_reg <= j_reg;
                j_reg      <= j_reg + IW'(1);
            end else begin
                pend_reg <= 1'b0;
            end
            if (pend_reg) begin
                if (red < minv_reg[pend_j_reg]) begin
                    minv_reg[pend_j_reg] <= red;
                    way_reg[pend_j_reg]  <= j0_reg;
                end
                if (cur_min < delta_reg) begin
                    delta_reg <= cur_min;
                    j1_reg    <= pend_j_reg;
                    found_reg <= 1'b1;
                end
            end else if (j_reg > n) begin
                j_reg <= '0;
            end
        end
        // potential update sweep over columns 0..n
        if (cmd.update) begin
            if (used_reg[j_reg]) begin
                u_reg[p_reg[j_reg]] <= u_reg[p_reg[j_reg]] + delta_reg;
                v_reg[j_reg]        <= v_reg[j_reg] - delta_reg;
            end else begin
                minv_reg[j_reg] <= minv_reg[j_reg] - delta_reg;
            end
            j_reg <= j_reg + IW'(1);
            if (j_reg == n) j0_reg <= j1_reg;
        end
        // augment one link a cycle
        if (cmd.aug_step) begin
            p_reg[j0_reg] <= p_reg[prev];
            j0_reg        <= prev;
            if (prev == '0) row_i_reg <= row_i_reg + IW'(1);
        end
        // output column search, weight fetch and sum
        if (cmd.out_start) j_reg <= IW'(1);
        if (cmd.out_find) begin
            if (status.find_done) ocol_reg <= j_reg;
            else                  j_reg    <= j_reg + IW'(1);
        end
        if (cmd.out_acc) begin
            total_reg <= total_reg + 20'(rdata_reg);
            if (!status.out_last) begin
                j_reg    <= IW'(1);
                orow_reg <= orow_reg + IW'(1);
            end
        end
    end

    // result rows, advanced on each accepted result transaction
    always_ff @(posedge aclk) begin
        if (cmd.out_acc) col_of_reg[orow_reg[3:0]] <= 4'(ocol_reg - IW'(1));
        if (!aresetn || cmd.init_clear) begin
            emit_reg <= '0;
        end else if (cmd.emit_next) begin
            emit_reg <= emit_reg + IW'(1);
        end
    end

    assign m_assigned_row    = 4'(emit_reg);
    assign m_assigned_column = col_of_reg[emit_reg[3:0]];
    assign m_last            = (emit_reg == IW'(n - IW'(1)));
    assign m_weight_sum      = m_last ? total_reg : 20'sd0;

endmodule
